### hdl/cvm_pkg.sv
// Shared types and constants for the colored voxel map block.
// Holds item structs, operation/status/register codes and fixed field widths.
// No dependencies.
package cvm_pkg;

  localparam int COORD_W = 24;
  localparam int KEY_W   = 16;
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 48;
  localparam int VSIZE_W = 16;
  localparam int MAXP_W  = 5;
  localparam int EVCNT_W = 11;
  localparam int COST_W  = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_EVICT  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_VOXEL_FULL = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_MATCH      = 3'd3,
    ST_NO_MATCH   = 3'd4,
    ST_EVICT_DONE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_VOXEL_SIZE = 2'd0,
    CFG_MAX_POINTS = 2'd1,
    CFG_CORR_LIMIT = 2'd2,
    CFG_KEEP_RADIUS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic [COLOR_W-1:0]         red;
    logic [COLOR_W-1:0]         green;
    logic [COLOR_W-1:0]         blue;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [COORD_W-1:0]  match_x;
    logic signed [COORD_W-1:0]  match_y;
    logic signed [COORD_W-1:0]  match_z;
    logic [COLOR_W-1:0]         match_red;
    logic [COLOR_W-1:0]         match_green;
    logic [COLOR_W-1:0]         match_blue;
    logic [EVCNT_W-1:0]         evicted_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [COLOR_W-1:0]         red;
    logic [COLOR_W-1:0]         green;
    logic [COLOR_W-1:0]         blue;
  } pt_word_t;

endpackage

### hdl/cvm_div.sv
// Restoring divider, one quotient bit per cycle, for voxel key computation.
// Depends on cvm_pkg for the coordinate and voxel size widths.
module cvm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cvm_pkg::COORD_W-1:0]  dividend,
  input  logic [cvm_pkg::VSIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [cvm_pkg::COORD_W-1:0]  quotient
);
  import cvm_pkg::*;

  localparam int CNT_W = $clog2(COORD_W);

  logic                  run_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [VSIZE_W-1:0]    rem_r;
  logic [VSIZE_W-1:0]    dvs_r;
  logic [COORD_W-1:0]    quo_r;
  logic [VSIZE_W:0]      shifted;
  logic                  fits;

  assign shifted  = {rem_r, quo_r[COORD_W-1]};
  assign fits     = shifted >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[COORD_W-2:0], fits};
      rem_r <= fits ? VSIZE_W'(shifted - {1'b0, dvs_r}) : shifted[VSIZE_W-1:0];
    end
  end

endmodule

### hdl/color_voxel_map_nearest_neighbor.sv
// Colored voxel map with insert, nearest-neighbor query and far-voxel eviction.
// Depends on cvm_pkg and instantiates cvm_div for the per-axis voxel keys.
// One item is worked at a time: busy stays high from acceptance until the result strobe.
//
// After reset the block sweeps the voxel table once before it takes items. Every
// insert, query or evict first forms three axis keys on the serial divider, then
// walks all voxel slots through the slot memory read port. A query reads each point
// of a voxel near the query point once, and its six squared differences go one by
// one through the shared multiplier; an evict does the same for the first point of
// each occupied slot with three differences. The result appears on out_item for one
// cycle with out_valid high and cannot be held off; operation 3 is taken and yields
// nothing.
module color_voxel_map_nearest_neighbor #(
  parameter int VOXEL_SLOTS      = 1024,
  parameter int POINTS_PER_VOXEL = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cvm_pkg::in_item_t           in_item,
  output logic                        out_valid,
  output cvm_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  cvm_pkg::cfg_idx_t           cfg_index,
  input  logic [cvm_pkg::CFG_W-1:0]   cfg_wdata
);
  import cvm_pkg::*;

  localparam int SLOT_W   = $clog2(VOXEL_SLOTS);
  localparam int FILL_W   = $clog2(POINTS_PER_VOXEL + 1);
  localparam int PT_DEPTH = VOXEL_SLOTS * POINTS_PER_VOXEL;
  localparam int PT_AW    = $clog2(PT_DEPTH);
  localparam int VKEY_W   = 3 * KEY_W;

  typedef struct packed {
    logic               valid;
    logic [VKEY_W-1:0]  key;
    logic [FILL_W-1:0]  fill;
  } slot_word_t;

  typedef enum logic [11:0] {
    S_INIT     = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_DIV_GO   = 12'b000000000100,
    S_DIV_WAIT = 12'b000000001000,
    S_SCAN_RD  = 12'b000000010000,
    S_SCAN_CHK = 12'b000000100000,
    S_PT_RD    = 12'b000001000000,
    S_MUL      = 12'b000010000000,
    S_COST     = 12'b000100000000,
    S_CMP      = 12'b001000000000,
    S_EV_CHK   = 12'b010000000000,
    S_FIN      = 12'b100000000000
  } state_t;

  state_t state_r;

  logic [VSIZE_W-1:0] vsize_r;
  logic [MAXP_W-1:0]  maxp_r;
  logic [CFG_W-1:0]   corr_r;
  logic [CFG_W-1:0]   keep_r;

  in_item_t          item_r;
  logic [KEY_W-1:0]  kx_r, ky_r, kz_r;
  logic [1:0]        axis_r;

  logic [SLOT_W-1:0] slot_cnt_r;
  slot_word_t        slot_mem [VOXEL_SLOTS];
  slot_word_t        slot_rd_r;
  pt_word_t          pt_mem [PT_DEPTH];
  pt_word_t          pt_rd_r;

  logic              hit_r, free_r;
  logic [SLOT_W-1:0] hit_slot_r, free_slot_r;
  logic [FILL_W-1:0] hit_fill_r;

  logic [4:0]        nbr_r;
  logic [FILL_W-1:0] p_r, fill_r;
  logic [2:0]        step_r;
  logic [COST_W-1:0] prod_r, psq_r, csq_r, cost_r;

  logic              found_r;
  logic [COST_W-1:0] best_cost_r, best_psq_r;
  logic [4:0]        best_nbr_r;
  pt_word_t          best_pt_r;

  logic [EVCNT_W-1:0] evict_cnt_r;
  logic               out_valid_r;
  out_item_t          out_r;
  out_item_t          fin_item;
  logic               pt_go;

  // divider hookup
  logic                       div_start;
  logic                       div_done;
  logic [COORD_W-1:0]         div_quo;
  logic [COORD_W-1:0]         div_dividend;
  logic [VSIZE_W-1:0]         div_divisor;
  logic signed [COORD_W-1:0]  axis_c;
  logic                       axis_neg;
  logic [COORD_W-1:0]         axis_mag;
  logic [KEY_W-1:0]           axis_key;

  // insert decisions
  logic [VKEY_W-1:0] q_key;
  logic [FILL_W-1:0] limit;
  logic              last_slot;

  // neighborhood check
  logic [KEY_W-1:0] dkx, dky, dkz;
  logic             nb_hit;
  logic [1:0]       ix, iy, iz;
  logic [4:0]       nb_idx;

  // shared multiplier
  logic signed [COORD_W:0] op_a, op_b, dif;
  logic [COORD_W-1:0]      mag;
  logic [2*COORD_W-1:0]    sq;
  logic [2:0]              last_step;
  logic                    better;

  // memory port controls
  logic              slot_we;
  logic [SLOT_W-1:0] slot_wa;
  slot_word_t        slot_wd;
  logic              pt_we;
  logic [PT_AW-1:0]  pt_wa;
  logic [PT_AW-1:0]  pt_ra;
  pt_word_t          pt_wd;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign q_key     = {kz_r, ky_r, kx_r};
  assign last_slot = (slot_cnt_r == SLOT_W'(VOXEL_SLOTS - 1));

  always_comb begin
    if (maxp_r == '0) begin
      limit = FILL_W'(1);
    end else if (32'(maxp_r) > POINTS_PER_VOXEL) begin
      limit = FILL_W'(POINTS_PER_VOXEL);
    end else begin
      limit = FILL_W'(maxp_r);
    end
  end

  always_comb begin
    case (axis_r)
      2'd0:    axis_c = item_r.pos_x;
      2'd1:    axis_c = item_r.pos_y;
      default: axis_c = item_r.pos_z;
    endcase
  end

  assign axis_neg     = axis_c[COORD_W-1];
  assign axis_mag     = axis_neg ? COORD_W'(0) - COORD_W'(axis_c) : COORD_W'(axis_c);
  assign div_dividend = {axis_mag[COORD_W-1:8], 8'h00};
  assign div_divisor  = (vsize_r == '0) ? VSIZE_W'(1) : vsize_r;
  assign div_start    = (state_r == S_DIV_GO);
  assign axis_key     = axis_neg ? KEY_W'(0) - div_quo[KEY_W-1:0] : div_quo[KEY_W-1:0];

  cvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign dkx = slot_rd_r.key[KEY_W-1:0] - kx_r;
  assign dky = slot_rd_r.key[2*KEY_W-1:KEY_W] - ky_r;
  assign dkz = slot_rd_r.key[3*KEY_W-1:2*KEY_W] - kz_r;

  function automatic logic [2:0] axis_off(input logic [KEY_W-1:0] d);
    if (d == '0) begin
      axis_off = 3'b101;
    end else if (d == KEY_W'(1)) begin
      axis_off = 3'b110;
    end else if (d == '1) begin
      axis_off = 3'b100;
    end else begin
      axis_off = 3'b000;
    end
  endfunction

  always_comb begin
    logic [2:0] ox, oy, oz;
    ox = axis_off(dkx);
    oy = axis_off(dky);
    oz = axis_off(dkz);
    ix = ox[1:0];
    iy = oy[1:0];
    iz = oz[1:0];
    nb_hit = ox[2] & oy[2] & oz[2];
    nb_idx = 5'(ix) * 5'd9 + 5'(iy) * 5'd3 + 5'(iz);
  end

  assign pt_go = (item_r.operation == OP_QUERY) ?
                 (slot_rd_r.valid && nb_hit && slot_rd_r.fill != '0) :
                 ((item_r.operation == OP_EVICT) && slot_rd_r.valid);

  always_comb begin
    case (step_r)
      3'd0: begin
        op_a = (COORD_W+1)'(pt_rd_r.x);
        op_b = (COORD_W+1)'(item_r.pos_x);
      end
      3'd1: begin
        op_a = (COORD_W+1)'(pt_rd_r.y);
        op_b = (COORD_W+1)'(item_r.pos_y);
      end
      3'd2: begin
        op_a = (COORD_W+1)'(pt_rd_r.z);
        op_b = (COORD_W+1)'(item_r.pos_z);
      end
      3'd3: begin
        op_a = (COORD_W+1)'({1'b0, pt_rd_r.red});
        op_b = (COORD_W+1)'({1'b0, item_r.red});
      end
      3'd4: begin
        op_a = (COORD_W+1)'({1'b0, pt_rd_r.green});
        op_b = (COORD_W+1)'({1'b0, item_r.green});
      end
      default: begin
        op_a = (COORD_W+1)'({1'b0, pt_rd_r.blue});
        op_b = (COORD_W+1)'({1'b0, item_r.blue});
      end
    endcase
    dif = op_a - op_b;
    mag = dif[COORD_W] ? COORD_W'(-dif) : COORD_W'(dif);
    sq  = mag * mag;
  end

  assign last_step = (item_r.operation == OP_QUERY) ? 3'd6 : 3'd3;
  assign better    = !found_r || (cost_r < best_cost_r) ||
                     ((cost_r == best_cost_r) && (nbr_r < best_nbr_r));

  always_comb begin
    fin_item = '0;
    case (item_r.operation)
      OP_INSERT: begin
        if (hit_r) begin
          fin_item.status = (hit_fill_r >= limit) ? ST_VOXEL_FULL : ST_STORED;
        end else begin
          fin_item.status = free_r ? ST_STORED : ST_TABLE_FULL;
        end
      end
      OP_QUERY: begin
        if (found_r && best_psq_r < COST_W'(corr_r)) begin
          fin_item.status      = ST_MATCH;
          fin_item.match_x     = best_pt_r.x;
          fin_item.match_y     = best_pt_r.y;
          fin_item.match_z     = best_pt_r.z;
          fin_item.match_red   = best_pt_r.red;
          fin_item.match_green = best_pt_r.green;
          fin_item.match_blue  = best_pt_r.blue;
        end else begin
          fin_item.status = ST_NO_MATCH;
        end
      end
      default: begin
        fin_item.status        = ST_EVICT_DONE;
        fin_item.evicted_count = evict_cnt_r;
      end
    endcase
  end

  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot_cnt_r;
    slot_wd = '{valid: 1'b0, key: slot_rd_r.key, fill: slot_rd_r.fill};
    pt_we   = 1'b0;
    pt_wa   = PT_AW'(hit_slot_r) * PT_AW'(POINTS_PER_VOXEL) + PT_AW'(hit_fill_r);
    pt_wd   = '{x: item_r.pos_x, y: item_r.pos_y, z: item_r.pos_z,
                red: item_r.red, green: item_r.green, blue: item_r.blue};
    pt_ra   = PT_AW'(slot_cnt_r) * PT_AW'(POINTS_PER_VOXEL) + PT_AW'(p_r);
    if (state_r == S_INIT) begin
      slot_we = 1'b1;
    end else if (state_r == S_EV_CHK) begin
      slot_we = (psq_r > COST_W'(keep_r));
    end else if (state_r == S_FIN && item_r.operation == OP_INSERT) begin
      if (hit_r) begin
        slot_we = (hit_fill_r < limit);
        pt_we   = (hit_fill_r < limit);
        slot_wa = hit_slot_r;
        slot_wd = '{valid: 1'b1, key: q_key, fill: hit_fill_r + 1'b1};
      end else begin
        slot_we = free_r;
        pt_we   = free_r;
        slot_wa = free_slot_r;
        slot_wd = '{valid: 1'b1, key: q_key, fill: FILL_W'(1)};
        pt_wa   = PT_AW'(free_slot_r) * PT_AW'(POINTS_PER_VOXEL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (state_r == S_SCAN_RD) begin
      slot_rd_r <= slot_mem[slot_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    if (state_r == S_PT_RD) begin
      pt_rd_r <= pt_mem[pt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsize_r <= VSIZE_W'(256);
      maxp_r  <= MAXP_W'(16);
      corr_r  <= CFG_W'(65536);
      keep_r  <= CFG_W'(6553600);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOXEL_SIZE:  vsize_r <= cfg_wdata[VSIZE_W-1:0];
        CFG_MAX_POINTS:  maxp_r  <= cfg_wdata[MAXP_W-1:0];
        CFG_CORR_LIMIT:  corr_r  <= cfg_wdata;
        CFG_KEEP_RADIUS: keep_r  <= cfg_wdata;
        default:         vsize_r <= vsize_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      slot_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      found_r     <= 1'b0;
      evict_cnt_r <= '0;
      axis_r      <= '0;
      step_r      <= '0;
      p_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_INIT: begin
          slot_cnt_r <= slot_cnt_r + 1'b1;
          if (last_slot) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_r      <= in_item;
            axis_r      <= '0;
            hit_r       <= 1'b0;
            free_r      <= 1'b0;
            found_r     <= 1'b0;
            evict_cnt_r <= '0;
            if (in_item.operation != OP_NONE) begin
              state_r <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (axis_r)
              2'd0:    kx_r <= axis_key;
              2'd1:    ky_r <= axis_key;
              default: kz_r <= axis_key;
            endcase
            if (axis_r == 2'd2) begin
              slot_cnt_r <= '0;
              state_r    <= S_SCAN_RD;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          nbr_r  <= nb_idx;
          fill_r <= slot_rd_r.fill;
          if (pt_go) begin
            p_r     <= '0;
            state_r <= S_PT_RD;
          end else begin
            state_r    <= last_slot ? S_FIN : S_SCAN_RD;
            slot_cnt_r <= last_slot ? slot_cnt_r : slot_cnt_r + 1'b1;
          end
          if (item_r.operation == OP_INSERT) begin
            if (slot_rd_r.valid && slot_rd_r.key == q_key && !hit_r) begin
              hit_r      <= 1'b1;
              hit_slot_r <= slot_cnt_r;
              hit_fill_r <= slot_rd_r.fill;
            end
            if (!slot_rd_r.valid && !free_r) begin
              free_r      <= 1'b1;
              free_slot_r <= slot_cnt_r;
            end
          end
        end
        S_PT_RD: begin
          psq_r   <= '0;
          csq_r   <= '0;
          step_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (step_r < last_step) begin
            prod_r <= COST_W'(sq);
          end
          if (step_r != '0) begin
            if (step_r <= 3'd3) begin
              psq_r <= psq_r + prod_r;
            end else begin
              csq_r <= csq_r + prod_r;
            end
          end
          step_r <= step_r + 1'b1;
          if (step_r == last_step) begin
            state_r <= (item_r.operation == OP_QUERY) ? S_COST : S_EV_CHK;
          end
        end
        S_COST: begin
          cost_r  <= (psq_r << 7) + (psq_r << 6) + (psq_r << 3) + (csq_r << 16);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (better) begin
            found_r     <= 1'b1;
            best_cost_r <= cost_r;
            best_psq_r  <= psq_r;
            best_nbr_r  <= nbr_r;
            best_pt_r   <= pt_rd_r;
          end
          if ((FILL_W+1)'(p_r) + 1'b1 < (FILL_W+1)'(fill_r)) begin
            p_r     <= p_r + 1'b1;
            state_r <= S_PT_RD;
          end else begin
            state_r    <= last_slot ? S_FIN : S_SCAN_RD;
            slot_cnt_r <= last_slot ? slot_cnt_r : slot_cnt_r + 1'b1;
          end
        end
        S_EV_CHK: begin
          if (psq_r > COST_W'(keep_r)) begin
            evict_cnt_r <= evict_cnt_r + 1'b1;
          end
          state_r    <= last_slot ? S_FIN : S_SCAN_RD;
          slot_cnt_r <= last_slot ? slot_cnt_r : slot_cnt_r + 1'b1;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_r       <= fin_item;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation != OP_NONE) |=> busy)
    else $error("accepted item did not raise busy");

  a_fin_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> last_slot)
    else $error("result formed before the slot walk ended");
`endif

endmodule

### test/tb_color_voxel_map_nearest_neighbor.sv
// Self-checking bench for the colored voxel map: inserts, nearest-neighbor queries, evicts.
// Drives the start/busy item port and the register port and checks strobed results
// against an in-bench map model. Depends on cvm_pkg and color_voxel_map_nearest_neighbor.
module tb_color_voxel_map_nearest_neighbor;
  timeunit 1ns;
  timeprecision 1ps;
  import cvm_pkg::*;

  localparam int SLOTS    = 64;
  localparam int PPV      = 16;
  localparam int WATCHDOG = 40000;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = CFG_VOXEL_SIZE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [15:0] vsize;
  logic [4:0]  maxp;
  logic [47:0] corr_lim;
  logic [47:0] keep_rad;
  bit          map_valid [SLOTS];
  logic [47:0] map_key [SLOTS];
  int          map_fill [SLOTS];
  pt_word_t    map_pt [SLOTS*PPV];

  out_item_t want_q[$];
  int        fails = 0;
  int        quiet = 0;
  row_t      rows[$];

  color_voxel_map_nearest_neighbor #(.VOXEL_SLOTS(SLOTS), .POINTS_PER_VOXEL(PPV)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    quiet++;
    if (quiet >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [15:0] axis_key(logic signed [COORD_W-1:0] c);
    longint w, k, vs;
    vs = (vsize == 0) ? 1 : longint'(vsize);
    w = longint'(c) / 256;
    k = (w * 256) / vs;
    return k[15:0];
  endfunction

  function automatic longint unsigned sqd(longint a, longint b);
    longint unsigned d;
    d = (a >= b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic longint unsigned pos_dist(pt_word_t p, in_item_t it);
    return sqd(p.x, it.pos_x) + sqd(p.y, it.pos_y) + sqd(p.z, it.pos_z);
  endfunction

  function automatic int find_voxel(logic [47:0] key);
    for (int s = 0; s < SLOTS; s++)
      if (map_valid[s] && map_key[s] == key) return s;
    return -1;
  endfunction

  function automatic out_item_t mk(status_t st, logic [23:0] x, logic [23:0] y,
                                   logic [23:0] z, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b, logic [10:0] n);
    out_item_t o;
    o = '{st, x, y, z, r, g, b, n};
    return o;
  endfunction

  task automatic map_predict(in_item_t it, output bit has, output out_item_t o);
    logic [15:0] kx, ky, kz;
    logic [47:0] key;
    int s, lim, idx, best_idx;
    bit found;
    longint unsigned best, best_pos, psq, csq, cost;
    pt_word_t p;
    kx = axis_key(it.pos_x);
    ky = axis_key(it.pos_y);
    kz = axis_key(it.pos_z);
    o = '0;
    has = 1'b1;
    case (it.operation)
      OP_INSERT: begin
        key = {kz, ky, kx};
        lim = (maxp < 1) ? 1 : (maxp > PPV) ? PPV : int'(maxp);
        s = find_voxel(key);
        if (s >= 0 && map_fill[s] >= lim) begin
          o.status = ST_VOXEL_FULL;
        end else begin
          if (s < 0) begin
            s = 0;
            while (s < SLOTS && map_valid[s]) s++;
          end
          if (s >= SLOTS) begin
            o.status = ST_TABLE_FULL;
          end else begin
            if (!map_valid[s] || map_key[s] != key) begin
              map_valid[s] = 1'b1;
              map_key[s] = key;
              map_fill[s] = 0;
            end
            map_pt[s*PPV + map_fill[s]] =
              '{it.pos_x, it.pos_y, it.pos_z, it.red, it.green, it.blue};
            map_fill[s]++;
            o.status = ST_STORED;
          end
        end
      end
      OP_QUERY: begin
        found = 1'b0;
        best = 0;
        best_pos = 0;
        best_idx = 0;
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++)
            for (int dz = -1; dz <= 1; dz++) begin
              key = {kz + 16'(dz), ky + 16'(dy), kx + 16'(dx)};
              s = find_voxel(key);
              if (s >= 0)
                for (int q = 0; q < map_fill[s] && q < PPV; q++) begin
                  idx = s*PPV + q;
                  p = map_pt[idx];
                  psq = pos_dist(p, it);
                  csq = sqd(p.red, it.red) + sqd(p.green, it.green) + sqd(p.blue, it.blue);
                  cost = 200 * psq + 65536 * csq;
                  if (!found || cost < best) begin
                    found = 1'b1;
                    best = cost;
                    best_pos = psq;
                    best_idx = idx;
                  end
                end
            end
        if (found && best_pos < corr_lim) begin
          p = map_pt[best_idx];
          o = mk(ST_MATCH, p.x, p.y, p.z, p.red, p.green, p.blue, '0);
        end else begin
          o.status = ST_NO_MATCH;
        end
      end
      OP_EVICT: begin
        idx = 0;
        for (s = 0; s < SLOTS; s++)
          if (map_valid[s] && pos_dist(map_pt[s*PPV], it) > keep_rad) begin
            map_valid[s] = 1'b0;
            idx++;
          end
        o.status = ST_EVICT_DONE;
        o.evicted_count = 11'(idx);
      end
      default: has = 1'b0;
    endcase
  endtask

  task automatic send_item(in_item_t it, int gap_pct, bit typed, out_item_t want);
    bit b, has;
    out_item_t o;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    forever begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
      if (!b) break;
    end
    quiet = 0;
    map_predict(it, has, o);
    if (has) want_q = {want_q, typed ? want : o};
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_VOXEL_SIZE: vsize = v[15:0];
      CFG_MAX_POINTS: maxp = v[4:0];
      CFG_CORR_LIMIT: corr_lim = v[47:0];
      default:        keep_rad = v[47:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    quiet = 0;
  endtask

  function automatic logic [23:0] rand_coord(bit wide);
    if (wide) return 24'($urandom);
    return 24'($urandom_range(4095)) - 24'd2048;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    bit wide;
    pick = $urandom_range(99);
    wide = ($urandom_range(99) < 20);
    it.operation = (pick < 50) ? OP_INSERT : (pick < 85) ? OP_QUERY :
                   (pick < 94) ? OP_EVICT : OP_NONE;
    it.pos_x = rand_coord(wide);
    it.pos_y = rand_coord(wide);
    it.pos_z = rand_coord(wide);
    it.red = 8'($urandom);
    it.green = 8'($urandom);
    it.blue = 8'($urandom);
    return it;
  endfunction

  function automatic row_t row(op_t op, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                               logic [7:0] c, bit typed, out_item_t want);
    row_t r;
    r.it = '{op, x, y, z, c, c, c};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  task automatic add_row(row_t r);
    rows = {rows, r};
  endtask

  always @(negedge clk) begin
    out_item_t w;
    if (rst_n && out_valid) begin
      quiet = 0;
      if (want_q.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        fails++;
      end else begin
        w = want_q.pop_front();
        if (out_item.status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_item.status);
          fails++;
        end
        if (out_item.match_x !== w.match_x) begin
          $error("match_x: expected %0d, got %0d", w.match_x, out_item.match_x);
          fails++;
        end
        if (out_item.match_y !== w.match_y) begin
          $error("match_y: expected %0d, got %0d", w.match_y, out_item.match_y);
          fails++;
        end
        if (out_item.match_z !== w.match_z) begin
          $error("match_z: expected %0d, got %0d", w.match_z, out_item.match_z);
          fails++;
        end
        if (out_item.match_red !== w.match_red) begin
          $error("match_red: expected %0d, got %0d", w.match_red, out_item.match_red);
          fails++;
        end
        if (out_item.match_green !== w.match_green) begin
          $error("match_green: expected %0d, got %0d", w.match_green, out_item.match_green);
          fails++;
        end
        if (out_item.match_blue !== w.match_blue) begin
          $error("match_blue: expected %0d, got %0d", w.match_blue, out_item.match_blue);
          fails++;
        end
        if (out_item.evicted_count !== w.evicted_count) begin
          $error("evicted_count: expected %0d, got %0d", w.evicted_count,
                 out_item.evicted_count);
          fails++;
        end
      end
    end
  end

  initial begin
    logic [47:0] phase_cfg [7][4];
    out_item_t nul;
    int gap;
    nul = '0;
    vsize = 16'd256;
    maxp = 5'd16;
    corr_lim = 48'd65536;
    keep_rad = 48'd6553600;
    for (int s = 0; s < SLOTS; s++) begin
      map_valid[s] = 1'b0;
      map_key[s] = '0;
      map_fill[s] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_row(row(OP_QUERY, 0, 0, 0, 0, 1, mk(ST_NO_MATCH, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(OP_EVICT, 0, 0, 0, 0, 1, mk(ST_EVICT_DONE, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(OP_INSERT, 0, 0, 0, 0, 1, mk(ST_STORED, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(OP_QUERY, 0, 0, 0, 0, 1, mk(ST_MATCH, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(OP_INSERT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'hFF, 1,
                mk(ST_STORED, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(OP_INSERT, 24'h800000, 24'h800000, 24'h800000, 8'h00, 1,
                mk(ST_STORED, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(OP_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'hFF, 1,
                mk(ST_MATCH, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'hFF, 8'hFF,
                   8'hFF, 0)));
    add_row(row(OP_NONE, 24'h123456, 0, 0, 8'h5A, 0, nul));
    add_row(row(OP_QUERY, 24'd256000, 24'd256000, 24'd256000, 0, 1,
                mk(ST_NO_MATCH, 0, 0, 0, 0, 0, 0, 0)));
    add_row(row(OP_INSERT, -24'sd128, 24'd300, -24'sd700, 8'h80, 0, nul));
    add_row(row(OP_QUERY, 24'd256, 0, 0, 8'h00, 0, nul));
    add_row(row(OP_QUERY, 24'd255, 0, 0, 8'h80, 0, nul));
    add_row(row(OP_INSERT, 24'h800000, 24'h800000, 24'h800000, 8'h11, 0, nul));
    add_row(row(OP_QUERY, 24'h800000, 24'h800000, 24'h800000, 8'h11, 0, nul));
    add_row(row(OP_EVICT, 0, 0, 0, 0, 0, nul));
    add_row(row(OP_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'hFF, 0, nul));
    foreach (rows[i]) send_item(rows[i].it, 0, rows[i].typed, rows[i].want);

    phase_cfg[0] = '{48'd256, 48'd16, 48'd65536, 48'd6553600};
    phase_cfg[1] = '{48'd0, 48'd0, 48'd0, 48'd0};
    phase_cfg[2] = '{48'hFFFF, 48'd31, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
    phase_cfg[3] = '{48'd64, 48'd3, 48'd1 << 20, 48'd1 << 22};
    phase_cfg[4] = '{48'd1024, 48'd16, 48'd1 << 24, 48'd1 << 30};
    phase_cfg[5] = '{48'd1, 48'd1, 48'd1 << 30, 48'd1 << 26};
    phase_cfg[6] = '{48'd512, 48'd8, 48'($urandom) << 4, 48'($urandom) >> 6};

    for (int ph = 0; ph < 7; ph++) begin
      drain_and_settle();
      write_reg(CFG_VOXEL_SIZE, phase_cfg[ph][0]);
      write_reg(CFG_MAX_POINTS, phase_cfg[ph][1]);
      write_reg(CFG_CORR_LIMIT, phase_cfg[ph][2]);
      write_reg(CFG_KEEP_RADIUS, phase_cfg[ph][3]);
      for (int n = 0; n < 100; n++) begin
        gap = (ph * 100 + n < 233) ? 26 : (ph * 100 + n < 466) ? 65 : 0;
        send_item(rand_item(), gap, 0, nul);
      end
    end

    drain_and_settle();
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
